/* hw/rtl/cpd_pkg.sv */
// ----------------------------------------------------------------------------
// cpd_pkg : shared types and codes for the contact pair event differ
// Request and result transfer layouts plus the event kind codes.
// ----------------------------------------------------------------------------
package cpd_pkg;

    localparam int FIELD_W = 16;   // width of an id on the ports
    localparam int KIND_W  = 3;

    localparam logic [KIND_W-1:0] KIND_ENTER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STAY   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXIT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DONE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd4;

    localparam logic REQ_PAIR = 1'b0;
    localparam logic REQ_EOF  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] entity_first;
        logic [FIELD_W-1:0] entity_second;
    } t_req;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [FIELD_W-1:0] pair_low;
        logic [FIELD_W-1:0] pair_high;
        logic               run_last;
    } t_result;

endpackage

/* hw/rtl/cpd_ram.sv */
// ----------------------------------------------------------------------------
// cpd_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/contact_pair_event_diff_top.sv */
// ----------------------------------------------------------------------------
// contact_pair_event_diff_top : per-frame contact pair event differ
// Merges each frame's ascending pair list against the previous frame's list
// and reports enter / stay / exit events, a frame done marker and rejects.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive i_req and raise start; the transfer happens on an
//   edge where start is high and busy is low. req_type selects a contact pair
//   or the end-of-frame marker. Pairs must come in ascending order.
//   Result channel: o_strobe marks a result on o_result for exactly one cycle;
//   the receiver cannot stall it. run_last flags the final result of a request.
//   Config: i_cfg_we writes i_cfg_wdata into the invalid entity id register;
//   write only while the block is idle; the block itself does not enforce it.
// Timing
//   A pair is accepted while idle, then each smaller old pair is retired as
//   an exit before its stay or enter result; an end-of-frame retires every
//   remaining old pair as an exit, then gives the done result. The pace is
//   set by the single read port of the pair RAM: one stored pair is read and
//   compared per cycle. The first result shows in the cycle after the evaluate
//   cycle that makes it. Dropped pairs (invalid, self, duplicate) give none.
// Reset
//   Synchronous, active low. Both lists read as empty afterwards; the RAM
//   itself is not cleared and needs no clearing pass, as only entries written
//   in an earlier frame are ever read.
// ----------------------------------------------------------------------------
module contact_pair_event_diff_top #(
    parameter int PAIR_DEPTH = 32,
    parameter int ID_BITS    = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  cpd_pkg::t_req    i_req,
    output logic             o_strobe,
    output cpd_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_wdata
);

    import cpd_pkg::*;

    localparam int KEY_W = 2 * ID_BITS;
    localparam int CNT_W = $clog2(PAIR_DEPTH + 1);
    localparam int ADR_W = $clog2(2 * PAIR_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    // control state
    logic             r_state,       n_state;
    logic             r_bank,        n_bank;       // bank holding previous list
    logic [CNT_W-1:0] r_prev_count,  n_prev_count;
    logic [CNT_W-1:0] r_cur_count,   n_cur_count;
    logic [CNT_W-1:0] r_ptr,         n_ptr;        // next old pair to retire
    logic [KEY_W-1:0] r_last_pair,   n_last_pair;
    logic             r_last_valid,  n_last_valid;
    logic [15:0]      r_invalid;
    logic             r_strobe,      n_strobe;

    // payload
    logic             r_eof,  n_eof;
    logic             r_drop, n_drop;
    logic [KEY_W-1:0] r_key,  n_key;
    t_result          r_res,  n_res;

    // request normalisation
    logic [ID_BITS+15:0] w_a_ext, w_b_ext, w_inv_ext;
    logic [ID_BITS-1:0]  w_a, w_b, w_inv, w_lo, w_hi;

    // RAM
    logic             w_we;
    logic [ADR_W-1:0] w_waddr, w_raddr;
    logic [KEY_W-1:0] w_old;

    // event payload formatting
    logic [KEY_W-1:0]    w_evt_key;
    logic [ID_BITS+15:0] w_lo_ext, w_hi_ext;

    logic w_old_avail, w_old_lt, w_old_eq;

    assign w_a_ext   = {{ID_BITS{1'b0}}, i_req.entity_first};
    assign w_b_ext   = {{ID_BITS{1'b0}}, i_req.entity_second};
    assign w_inv_ext = {{ID_BITS{1'b0}}, r_invalid};
    assign w_a       = w_a_ext[ID_BITS-1:0];
    assign w_b       = w_b_ext[ID_BITS-1:0];
    assign w_inv     = w_inv_ext[ID_BITS-1:0];
    assign w_lo      = (w_a <= w_b) ? w_a : w_b;
    assign w_hi      = (w_a <= w_b) ? w_b : w_a;

    assign w_old_avail = (r_ptr < r_prev_count);
    assign w_old_lt    = (w_old < r_key);
    assign w_old_eq    = (w_old == r_key);

    assign w_lo_ext = {16'd0, w_evt_key[KEY_W-1:ID_BITS]};
    assign w_hi_ext = {16'd0, w_evt_key[ID_BITS-1:0]};

    // read always targets the pointer of the coming cycle, so w_old is the
    // old pair at r_ptr in every cycle
    assign w_raddr = n_bank ? ADR_W'(PAIR_DEPTH) + ADR_W'(n_ptr) : ADR_W'(n_ptr);
    assign w_waddr = r_bank ? ADR_W'(r_cur_count)
                            : ADR_W'(PAIR_DEPTH) + ADR_W'(r_cur_count);

    always_comb begin
        n_state      = r_state;
        n_bank       = r_bank;
        n_prev_count = r_prev_count;
        n_cur_count  = r_cur_count;
        n_ptr        = r_ptr;
        n_last_pair  = r_last_pair;
        n_last_valid = r_last_valid;
        n_strobe     = 1'b0;
        n_eof        = r_eof;
        n_drop       = r_drop;
        n_key        = r_key;
        n_res        = r_res;
        w_we         = 1'b0;
        w_evt_key    = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_eof   = (i_req.req_type == REQ_EOF);
                    n_key   = {w_lo, w_hi};
                    n_drop  = (w_lo == w_inv) || (w_hi == w_inv) || (w_lo == w_hi);
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (r_eof) begin
                    if (w_old_avail) begin
                        w_evt_key        = w_old;
                        n_strobe         = 1'b1;
                        n_res.event_kind = KIND_EXIT;
                        n_res.run_last   = 1'b0;
                        n_ptr            = r_ptr + CNT_W'(1);
                    end else begin
                        w_evt_key        = '0;
                        n_strobe         = 1'b1;
                        n_res.event_kind = KIND_DONE;
                        n_res.run_last   = 1'b1;
                        n_bank           = ~r_bank;
                        n_prev_count     = r_cur_count;
                        n_cur_count      = '0;
                        n_ptr            = '0;
                        n_last_pair      = '0;
                        n_last_valid     = 1'b0;
                        n_state          = S_IDLE;
                    end
                end else if (r_drop || (r_last_valid && r_key == r_last_pair)) begin
                    n_state = S_IDLE;
                end else if ((r_last_valid && r_key < r_last_pair)
                             || r_cur_count >= CNT_W'(PAIR_DEPTH)) begin
                    n_strobe         = 1'b1;
                    n_res.event_kind = KIND_REJECT;
                    n_res.run_last   = 1'b1;
                    n_state          = S_IDLE;
                end else if (w_old_avail && w_old_lt) begin
                    w_evt_key        = w_old;
                    n_strobe         = 1'b1;
                    n_res.event_kind = KIND_EXIT;
                    n_res.run_last   = 1'b0;
                    n_ptr            = r_ptr + CNT_W'(1);
                end else begin
                    n_strobe         = 1'b1;
                    n_res.run_last   = 1'b1;
                    if (w_old_avail && w_old_eq) begin
                        n_res.event_kind = KIND_STAY;
                        n_ptr            = r_ptr + CNT_W'(1);
                    end else begin
                        n_res.event_kind = KIND_ENTER;
                    end
                    // current list lives in the other bank: no overlap with reads
                    w_we         = 1'b1;
                    n_cur_count  = r_cur_count + CNT_W'(1);
                    n_last_pair  = r_key;
                    n_last_valid = 1'b1;
                    n_state      = S_IDLE;
                end
                n_res.pair_low  = w_lo_ext[15:0];
                n_res.pair_high = w_hi_ext[15:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bank       <= 1'b0;
            r_prev_count <= '0;
            r_cur_count  <= '0;
            r_ptr        <= '0;
            r_last_pair  <= '0;
            r_last_valid <= 1'b0;
            r_invalid    <= 16'hFFFF;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bank       <= n_bank;
            r_prev_count <= n_prev_count;
            r_cur_count  <= n_cur_count;
            r_ptr        <= n_ptr;
            r_last_pair  <= n_last_pair;
            r_last_valid <= n_last_valid;
            r_strobe     <= n_strobe;
            if (i_cfg_we) begin
                r_invalid <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eof  <= n_eof;
        r_drop <= n_drop;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    cpd_ram #(
        .WIDTH (KEY_W),
        .DEPTH (2 * PAIR_DEPTH)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_key),
        .i_raddr (w_raddr),
        .o_rdata (w_old)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // results only ever come out of an evaluate cycle
    a_strobe_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_EVAL))
        else $error("result without evaluate cycle");

    a_cur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_count <= CNT_W'(PAIR_DEPTH))
        else $error("current list overflow");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_prev_count)
        else $error("old pointer past previous list");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not start work");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.event_kind == KIND_DONE)
            |-> (r_ptr == '0 && r_cur_count == '0 && !r_last_valid))
        else $error("frame end left stale state");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for contact_pair_event_diff_top
// Feeds frames of ascending contact pairs, with dropped, repeated, out-of-order
// and over-full traffic mixed in, under random idling and invalid-id settings.
// A local merge of the old and new pair lists gives the expected event stream,
// and every result transfer is checked against it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import cpd_pkg::*;

    localparam int PAIR_DEPTH     = 32;
    localparam int ID_BITS        = 16;
    localparam int RANDOM_ITEMS   = 160;
    // dropped pairs give no result but still keep the block busy
    localparam int SETTLE_CYCLES  = 4;
    // longest request retires every old pair (PAIR_DEPTH of them)
    localparam int TAIL_CYCLES    = 40;
    // longest quiet stretch in a correct run is a request gap, a settle and
    // a register write, or the tail above; this is many times that
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {JOB_REQ, JOB_CFG, JOB_SYNC} t_job_kind;

    // one entry of the stimulus queue: a request, a register write, or a
    // hold-off until the block has drained
    typedef struct packed {
        t_job_kind   kind;
        t_req        req;
        logic [15:0] cfg;
        logic [3:0]  gap;
    } t_job;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_req        i_req       = '0;
    logic        o_strobe;
    t_result     o_result;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    contact_pair_event_diff_top #(
        .PAIR_DEPTH (PAIR_DEPTH),
        .ID_BITS    (ID_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Pair-list merge predictor. Two banks of sorted keys {low id, high id};
    // old_bank holds last frame's list, the other bank fills with this one.
    // ------------------------------------------------------------------------
    logic [31:0] pair_mem [0:2*PAIR_DEPTH-1];
    logic        old_bank = 1'b0;
    int          old_cnt  = 0;
    int          new_cnt  = 0;
    int          old_ptr  = 0;
    logic [31:0] last_key = '0;
    logic        last_ok  = 1'b0;
    logic [15:0] inv_id   = 16'hFFFF;
    t_result     step_events[$];
    t_result     due_events[$];     // expected results, oldest first

    function automatic logic [31:0] old_key(int idx);
        return pair_mem[(old_bank ? PAIR_DEPTH : 0) + idx];
    endfunction

    function automatic void add_event(logic [KIND_W-1:0] kind, logic [31:0] key);
        t_result r;
        r.event_kind = kind;
        r.pair_low   = key[31:16];
        r.pair_high  = key[15:0];
        r.run_last   = 1'b0;
        step_events.insert(step_events.size(), r);
    endfunction

    task automatic derive_events(input t_req rq);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [31:0] key;
        t_result     r;
        step_events.delete();
        if (rq.req_type == REQ_EOF) begin
            // flush what is left of the old list, then swap banks
            while (old_ptr < old_cnt) begin
                add_event(KIND_EXIT, old_key(old_ptr));
                old_ptr++;
            end
            add_event(KIND_DONE, '0);
            old_bank = ~old_bank;
            old_cnt  = new_cnt;
            new_cnt  = 0;
            old_ptr  = 0;
            last_key = '0;
            last_ok  = 1'b0;
        end else begin
            lo  = (rq.entity_first <= rq.entity_second) ? rq.entity_first : rq.entity_second;
            hi  = (rq.entity_first <= rq.entity_second) ? rq.entity_second : rq.entity_first;
            key = {lo, hi};
            if (lo == inv_id || hi == inv_id || lo == hi || (last_ok && key == last_key)) begin
                // invalid, self or repeated pair: silently dropped
            end else if ((last_ok && key < last_key) || new_cnt >= PAIR_DEPTH) begin
                // order check ahead of the full check; both reject the same way
                add_event(KIND_REJECT, key);
            end else begin
                while (old_ptr < old_cnt && old_key(old_ptr) < key) begin
                    add_event(KIND_EXIT, old_key(old_ptr));
                    old_ptr++;
                end
                if (old_ptr < old_cnt && old_key(old_ptr) == key) begin
                    add_event(KIND_STAY, key);
                    old_ptr++;
                end else begin
                    add_event(KIND_ENTER, key);
                end
                pair_mem[(old_bank ? 0 : PAIR_DEPTH) + new_cnt] = key;
                new_cnt++;
                last_key = key;
                last_ok  = 1'b1;
            end
        end
        for (int i = 0; i < step_events.size(); i++) begin
            r = step_events[i];
            r.run_last = (i == step_events.size() - 1);
            due_events.insert(due_events.size(), r);
        end
    endtask

    int errors = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: results first, then a register write, then an accepted request,
    // so a request on the edge after a write sees the new invalid id.
    // ------------------------------------------------------------------------
    logic req_taken      = 1'b0;
    int   requests_taken = 0;
    int   kind_seen [0:7] = '{default: 0};

    always @(posedge i_clk) begin : mon
        t_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                kind_seen[o_result.event_kind]++;
                if (due_events.size() == 0) begin
                    report_mismatch($sformatf("result with nothing due: kind %0d pair %0d/%0d",
                                              o_result.event_kind, o_result.pair_low,
                                              o_result.pair_high));
                end else begin
                    want = due_events.pop_front();
                    if (o_result.event_kind !== want.event_kind)
                        report_mismatch($sformatf("event_kind %0d, expected %0d (pair %0d/%0d)",
                                                  o_result.event_kind, want.event_kind,
                                                  want.pair_low, want.pair_high));
                    if (o_result.pair_low !== want.pair_low)
                        report_mismatch($sformatf("pair_low %0d, expected %0d",
                                                  o_result.pair_low, want.pair_low));
                    if (o_result.pair_high !== want.pair_high)
                        report_mismatch($sformatf("pair_high %0d, expected %0d",
                                                  o_result.pair_high, want.pair_high));
                    if (o_result.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %0b, expected %0b (kind %0d)",
                                                  o_result.run_last, want.run_last,
                                                  want.event_kind));
                end
            end
            if (i_cfg_we)
                inv_id = i_cfg_wdata;
            if (start && !busy) begin
                derive_events(i_req);
                requests_taken++;
            end
        end
        req_taken <= i_rst_n && start && !busy;
    end

    // ------------------------------------------------------------------------
    // Driver: works through the stimulus queue on the falling edge. Each job
    // waits out its own gap; start stays high across back-to-back transfers.
    // ------------------------------------------------------------------------
    t_job job_q[$];
    t_job cur_job;
    logic have_job     = 1'b0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;

    always @(negedge i_clk) begin : drv
        logic nxt_start;
        logic nxt_we;
        nxt_start = start;
        nxt_we    = 1'b0;
        if (i_rst_n) begin
            if (start && req_taken)
                nxt_start = 1'b0;
            if (!have_job && job_q.size() > 0) begin
                cur_job      = job_q.pop_front();
                have_job     = 1'b1;
                hold_left    = cur_job.gap;
                quiet_cycles = 0;
            end
            if (have_job && !nxt_start) begin
                if (hold_left > 0) begin
                    hold_left--;
                end else begin
                    case (cur_job.kind)
                        JOB_REQ: begin
                            nxt_start = 1'b1;
                            i_req    <= cur_job.req;
                            have_job  = 1'b0;
                        end
                        JOB_CFG: begin
                            nxt_we       = 1'b1;
                            i_cfg_wdata <= cur_job.cfg;
                            have_job     = 1'b0;
                        end
                        default: begin
                            // hold off until all due results are in and the
                            // block has been quiet for a few cycles
                            if (due_events.size() == 0 && !busy)
                                quiet_cycles++;
                            else
                                quiet_cycles = 0;
                            if (quiet_cycles >= SETTLE_CYCLES)
                                have_job = 1'b0;
                        end
                    endcase
                end
            end
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // ------------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------------
    logic [15:0] plan_inv      = 16'hFFFF;
    logic        plan_burst    = 1'b0;
    logic [31:0] plan_prev[$];
    logic [31:0] frame_keys[$];
    int          planned_items = 0;
    int          settings_used = 1;

    task automatic queue_req(input logic rtype, input logic [15:0] a, input logic [15:0] b);
        t_job j;
        j                   = '0;
        j.kind              = JOB_REQ;
        j.req.req_type      = rtype;
        j.req.entity_first  = a;
        j.req.entity_second = b;
        j.gap               = plan_burst ? 4'd0 : 4'($urandom_range(0, 9));
        job_q.insert(job_q.size(), j);
    endtask

    task automatic queue_sync();
        t_job j;
        j      = '0;
        j.kind = JOB_SYNC;
        job_q.insert(job_q.size(), j);
    endtask

    task automatic queue_cfg(input logic [15:0] v);
        t_job j;
        queue_sync();
        j      = '0;
        j.kind = JOB_CFG;
        j.cfg  = v;
        job_q.insert(job_q.size(), j);
        plan_inv = v;
        settings_used++;
    endtask

    function automatic void keep_sorted(logic [31:0] k);
        int pos;
        pos = 0;
        while (pos < frame_keys.size() && frame_keys[pos] < k)
            pos++;
        if (pos == frame_keys.size() || frame_keys[pos] != k)
            frame_keys.insert(pos, k);
    endfunction

    // stray traffic between good pairs; 'emitted' pairs of the frame went out
    task automatic add_noise(input int emitted);
        logic [15:0] x;
        logic [31:0] k;
        x = 16'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                queue_req(REQ_PAIR, x, x);
            end
            1: begin
                if ($urandom_range(0, 1))
                    queue_req(REQ_PAIR, plan_inv, x);
                else
                    queue_req(REQ_PAIR, x, plan_inv);
            end
            2: begin
                if (emitted > 0) begin
                    k = frame_keys[emitted - 1];
                    queue_req(REQ_PAIR, k[15:0], k[31:16]);
                end
            end
            default: begin
                // an earlier pair of this frame: ranks below the last one
                if (emitted > 1) begin
                    k = frame_keys[$urandom_range(0, emitted - 2)];
                    queue_req(REQ_PAIR, k[31:16], k[15:0]);
                end
            end
        endcase
    endtask

    // one frame: part of last frame's list carried over, fresh pairs added,
    // sent in ascending order with random orientation, then end of frame
    task automatic plan_frame(input int target);
        logic [15:0] a;
        logic [15:0] b;
        logic [31:0] k;
        int          tries;
        frame_keys.delete();
        foreach (plan_prev[i]) begin
            k = plan_prev[i];
            if ($urandom_range(0, 2) != 0 && k[31:16] != plan_inv && k[15:0] != plan_inv)
                keep_sorted(k);
        end
        tries = 0;
        while (frame_keys.size() < target && tries < 500) begin
            tries++;
            if ($urandom_range(0, 1)) begin
                a = 16'($urandom_range(0, 47));
                b = 16'($urandom_range(0, 47));
            end else begin
                a = 16'($urandom);
                b = 16'($urandom);
            end
            if (a != b && a != plan_inv && b != plan_inv)
                keep_sorted(a < b ? {a, b} : {b, a});
        end
        foreach (frame_keys[i]) begin
            k = frame_keys[i];
            if ($urandom_range(0, 9) == 0)
                add_noise(i);
            if ($urandom_range(0, 1))
                queue_req(REQ_PAIR, k[31:16], k[15:0]);
            else
                queue_req(REQ_PAIR, k[15:0], k[31:16]);
            planned_items++;
        end
        if ($urandom_range(0, 4) == 0)
            add_noise(frame_keys.size());
        queue_req(REQ_EOF, 16'($urandom), 16'($urandom));
        planned_items++;
        // anything past the store depth is rejected, so never stored
        plan_prev.delete();
        foreach (frame_keys[i]) begin
            if (i < PAIR_DEPTH)
                plan_prev.insert(plan_prev.size(), frame_keys[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int target;

        // directed frames, invalid id at its reset value (all ones)
        queue_req(REQ_PAIR, 16'd2, 16'd1);            // enter, ids swapped
        queue_req(REQ_PAIR, 16'd3, 16'd5);            // enter
        queue_req(REQ_PAIR, 16'd5, 16'd3);            // repeat of last: dropped
        queue_req(REQ_PAIR, 16'd7, 16'd7);            // self pair: dropped
        queue_req(REQ_PAIR, 16'hFFFF, 16'd4);         // invalid id: dropped
        queue_req(REQ_PAIR, 16'd1, 16'd2);            // below last: rejected
        queue_req(REQ_PAIR, 16'd0, 16'hFFFE);         // lowest low id, still below
        queue_req(REQ_PAIR, 16'hFFFE, 16'hFFFD);      // enter, top of range
        queue_req(REQ_EOF, 16'hFFFF, 16'hFFFF);       // no old list: done only
        queue_req(REQ_PAIR, 16'd1, 16'd2);            // stay
        queue_req(REQ_PAIR, 16'd6, 16'd4);            // exit 3/5, enter 4/6
        queue_req(REQ_EOF, 16'd0, 16'd0);             // exit FFFD/FFFE, done
        queue_req(REQ_PAIR, 16'd0, 16'd1);            // enter below all old
        queue_req(REQ_EOF, 16'hA5A5, 16'h5A5A);       // exits 1/2 and 4/6
        queue_req(REQ_EOF, 16'd0, 16'd0);             // exit 0/1 on empty frame
        queue_req(REQ_EOF, 16'd0, 16'd0);             // both lists empty
        queue_cfg(16'h0000);
        queue_req(REQ_PAIR, 16'd9, 16'd0);            // id 0 now invalid
        queue_req(REQ_PAIR, 16'hFFFF, 16'hFFFE);      // all-ones id now valid
        queue_req(REQ_EOF, 16'd0, 16'd0);

        // random phases, each under its own invalid id; the first frame
        // targets 30 to 36 pairs, about the store depth
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    queue_cfg(16'($urandom_range(1, 65534)));
                end
                1: begin
                    queue_cfg(16'hFFFF);
                end
                2: begin
                    queue_cfg(16'h0000);
                end
                default: begin
                    queue_cfg(16'($urandom_range(1, 65534)));
                end
            endcase
            while (planned_items < (p + 1) * RANDOM_ITEMS / 4) begin
                plan_burst = ($urandom_range(0, 3) == 0);
                if (planned_items == 0 || $urandom_range(0, 7) == 0)
                    target = $urandom_range(30, 36);
                else
                    target = $urandom_range(0, 10);
                plan_frame(target);
                if ($urandom_range(0, 5) == 0)
                    queue_sync();
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() != 0 || have_job || start || due_events.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_events.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      due_events.size()));

        $display("covered %0d request transfers over %0d frames, %0d invalid-id settings",
                 requests_taken, kind_seen[KIND_DONE], settings_used);
        $display("results seen: enter %0d, stay %0d, exit %0d, rejected %0d",
                 kind_seen[KIND_ENTER], kind_seen[KIND_STAY], kind_seen[KIND_EXIT],
                 kind_seen[KIND_REJECT]);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog: cycles with neither a request nor a result transfer
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
